// ===== rtl/cave_pkg.sv =====
package cave_pkg;

	// fixed field widths
	localparam int ROW_W  = 64;
	localparam int RNUM_W = 16;
	localparam int GW_W   = 7;
	localparam int THR_W  = 4;
	localparam int CFG_IDX_W  = 4;
	localparam int CFG_DATA_W = 16;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_GRID_WIDTH  = 4'd0;
	localparam logic [CFG_IDX_W-1:0] REG_GRID_HEIGHT = 4'd1;
	localparam logic [CFG_IDX_W-1:0] REG_BIRTH_COUNT = 4'd2;
	localparam logic [CFG_IDX_W-1:0] REG_DEATH_COUNT = 4'd3;

	// reset values of the registers
	localparam logic [GW_W-1:0]   GRID_WIDTH_RST  = 7'd64;
	localparam logic [RNUM_W-1:0] GRID_HEIGHT_RST = 16'd64;
	localparam logic [THR_W-1:0]  BIRTH_RST       = 4'd4;
	localparam logic [THR_W-1:0]  DEATH_RST       = 4'd3;

	// smallest grid edge
	localparam logic [GW_W-1:0]   MIN_WIDTH  = 7'd3;
	localparam logic [RNUM_W-1:0] MIN_HEIGHT = 16'd3;

	// one result beat
	typedef struct packed {
		logic [ROW_W-1:0]  new_row;
		logic [RNUM_W-1:0] row_number;
		logic              last_of_grid;
		logic              last_of_run;
	} res_t;

endpackage

// ===== rtl/cave_lane.sv =====
module cave_lane (
	input  logic [2:0]                up,
	input  logic [2:0]                mid,
	input  logic [2:0]                dn,
	input  logic [cave_pkg::THR_W-1:0] birth,
	input  logic [cave_pkg::THR_W-1:0] death,
	output logic                      alive
);

	logic [cave_pkg::THR_W-1:0] cnt;

	// live neighbours of the centre cell
	assign cnt = {3'b000, up[0]} + {3'b000, up[1]} + {3'b000, up[2]}
		+ {3'b000, mid[0]} + {3'b000, mid[2]}
		+ {3'b000, dn[0]} + {3'b000, dn[1]} + {3'b000, dn[2]};

	// survive unless below death, birth when above birth
	assign alive = mid[1] ? (cnt >= death) : (cnt > birth);

endmodule

// ===== rtl/cave_row_unit.sv =====
module cave_row_unit #(
	parameter int WIDTH = 64
) (
	input  logic [WIDTH-1:0]           up,
	input  logic [WIDTH-1:0]           mid,
	input  logic [WIDTH-1:0]           dn,
	input  logic [WIDTH-1:0]           imask,
	input  logic [cave_pkg::THR_W-1:0] birth,
	input  logic [cave_pkg::THR_W-1:0] death,
	output logic [WIDTH-1:0]           nrow
);

	logic [WIDTH-1:0] alive;

	// edge columns never live
	assign alive[0]       = 1'b0;
	assign alive[WIDTH-1] = 1'b0;

	// one lane per interior column
	for (genvar c = 1; c < WIDTH - 1; c++) begin : g_lane
		cave_lane u_lane (
			.up    (up[c+1:c-1]),
			.mid   (mid[c+1:c-1]),
			.dn    (dn[c+1:c-1]),
			.birth (birth),
			.death (death),
			.alive (alive[c])
		);
	end

	// merge lanes, keep interior of the active width only
	assign nrow = alive & imask;

endmodule

// ===== rtl/cave_out_fifo.sv =====
module cave_out_fifo (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  cave_pkg::res_t  push_data,
	output logic            push_ready,
	output logic            pop_valid,
	input  logic            pop_ready,
	output cave_pkg::res_t  pop_data
);

	cave_pkg::res_t mem_q [2];
	logic           wr_ptr_q;
	logic           rd_ptr_q;
	logic [1:0]     cnt_q;
	logic           do_push;
	logic           do_pop;

	assign push_ready = (cnt_q != 2'd2);
	assign pop_valid  = (cnt_q != 2'd0);
	assign do_push    = push && push_ready;
	assign do_pop     = pop_valid && pop_ready;
	assign pop_data   = mem_q[rd_ptr_q];

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (do_push)
				wr_ptr_q <= ~wr_ptr_q;
			if (do_pop)
				rd_ptr_q <= ~rd_ptr_q;
			if (do_push && !do_pop)
				cnt_q <= cnt_q + 2'd1;
			else if (do_pop && !do_push)
				cnt_q <= cnt_q - 2'd1;
		end
	end

	// result storage
	always_ff @(posedge clk) begin
		if (do_push)
			mem_q[wr_ptr_q] <= push_data;
	end

endmodule

// ===== rtl/cave_automaton_row_step_core.sv =====
// channel | direction | beat content                         | handshake
// cfg     | in        | cfg_index, cfg_data                  | cfg_valid / cfg_ready
// in      | in        | row_bits                             | in_valid / in_ready
// out     | out       | new_row, row_number, last_of_grid,   | out_valid / out_ready
//         |           | last_of_run                          |
//
// one row beat is taken per cycle while in_ready is high; the beat is
// registered, the lanes of the row unit evaluate it in the next cycle
// and the result goes into a two-entry output queue.
// the final row of a grid gives two results and holds the input until the second is pushed.
// reset clears rows, row counter, queue and restores register defaults.
// a stalled output fills the queue, then in_ready drops; cfg_ready is always high.
module cave_automaton_row_step_core #(
	parameter int MAX_WIDTH = 64
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [cave_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [cave_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [cave_pkg::ROW_W-1:0]          row_bits,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [cave_pkg::ROW_W-1:0]          new_row,
	output logic [cave_pkg::RNUM_W-1:0]         row_number,
	output logic                                last_of_grid,
	output logic                                last_of_run
);

	typedef enum logic [1:0] {
		KIND_ZERO,
		KIND_NORMAL,
		KIND_FINAL
	} kind_t;

	// configuration registers
	logic [cave_pkg::GW_W-1:0]   grid_width_q;
	logic [cave_pkg::RNUM_W-1:0] grid_height_q;
	logic [cave_pkg::THR_W-1:0]  birth_q;
	logic [cave_pkg::THR_W-1:0]  death_q;

	// row window and counter
	logic [MAX_WIDTH-1:0]        above_q;
	logic [MAX_WIDTH-1:0]        middle_q;
	logic [cave_pkg::RNUM_W-1:0] row_cnt_q;

	// evaluation stage
	logic                        valid_s1;
	logic                        phase_s1;
	kind_t                       kind_s1;
	logic [MAX_WIDTH-1:0]        up_s1;
	logic [MAX_WIDTH-1:0]        mid_s1;
	logic [MAX_WIDTH-1:0]        dn_s1;
	logic [MAX_WIDTH-1:0]        imask_s1;
	logic [cave_pkg::RNUM_W-1:0] rnum_s1;

	logic [cave_pkg::GW_W-1:0]   w_eff;
	logic [cave_pkg::RNUM_W-1:0] h_eff;
	logic [MAX_WIDTH-1:0]        wmask;
	logic [MAX_WIDTH-1:0]        imask;
	logic [MAX_WIDTH-1:0]        cur;
	logic                        is_final;
	logic                        in_acc;
	logic [MAX_WIDTH-1:0]        nrow;
	cave_pkg::res_t              res;
	cave_pkg::res_t              q_data;
	logic                        q_ready;
	logic                        push;
	logic                        last_emit;
	logic                        release_s1;

	assign cfg_ready = 1'b1;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_width_q  <= cave_pkg::GRID_WIDTH_RST;
			grid_height_q <= cave_pkg::GRID_HEIGHT_RST;
			birth_q       <= cave_pkg::BIRTH_RST;
			death_q       <= cave_pkg::DEATH_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				cave_pkg::REG_GRID_WIDTH:  grid_width_q  <= cfg_data[cave_pkg::GW_W-1:0];
				cave_pkg::REG_GRID_HEIGHT: grid_height_q <= cfg_data;
				cave_pkg::REG_BIRTH_COUNT: birth_q       <= cfg_data[cave_pkg::THR_W-1:0];
				cave_pkg::REG_DEATH_COUNT: death_q       <= cfg_data[cave_pkg::THR_W-1:0];
				default: ;
			endcase
		end
	end

	// clamped grid size
	always_comb begin
		if (grid_width_q < cave_pkg::MIN_WIDTH)
			w_eff = cave_pkg::MIN_WIDTH;
		else if (grid_width_q > cave_pkg::GW_W'(MAX_WIDTH))
			w_eff = cave_pkg::GW_W'(MAX_WIDTH);
		else
			w_eff = grid_width_q;
		h_eff = (grid_height_q < cave_pkg::MIN_HEIGHT) ? cave_pkg::MIN_HEIGHT : grid_height_q;
	end

	// column masks for the active width
	for (genvar i = 0; i < MAX_WIDTH; i++) begin : g_mask
		assign wmask[i] = (cave_pkg::GW_W'(i) < w_eff);
		assign imask[i] = (i != 0) && (cave_pkg::GW_W'(i + 1) < w_eff);
	end

	assign cur      = row_bits[MAX_WIDTH-1:0] & wmask;
	assign is_final = (row_cnt_q >= h_eff - 16'd1);

	// emission from the evaluation stage
	assign push       = valid_s1 && q_ready;
	assign last_emit  = (kind_s1 != KIND_FINAL) || phase_s1;
	assign release_s1 = push && last_emit;
	assign in_ready   = !valid_s1 || release_s1;
	assign in_acc     = in_valid && in_ready;

	// row window, counter and stage load
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			above_q   <= '0;
			middle_q  <= '0;
			row_cnt_q <= '0;
			valid_s1  <= 1'b0;
			phase_s1  <= 1'b0;
			kind_s1   <= KIND_ZERO;
		end else begin
			if (in_acc) begin
				phase_s1 <= 1'b0;
				if (row_cnt_q == 16'd0) begin
					middle_q  <= cur;
					row_cnt_q <= 16'd1;
					valid_s1  <= 1'b1;
					kind_s1   <= KIND_ZERO;
				end else if (row_cnt_q == 16'd1) begin
					above_q   <= middle_q;
					middle_q  <= cur;
					row_cnt_q <= 16'd2;
					valid_s1  <= 1'b0;
				end else if (is_final) begin
					above_q   <= '0;
					middle_q  <= '0;
					row_cnt_q <= '0;
					valid_s1  <= 1'b1;
					kind_s1   <= KIND_FINAL;
				end else begin
					above_q   <= middle_q;
					middle_q  <= cur;
					row_cnt_q <= row_cnt_q + 16'd1;
					valid_s1  <= 1'b1;
					kind_s1   <= KIND_NORMAL;
				end
			end else if (release_s1) begin
				valid_s1 <= 1'b0;
			end else if (push) begin
				phase_s1 <= 1'b1;
			end
		end
	end

	// stage operands
	always_ff @(posedge clk) begin
		if (in_acc) begin
			up_s1    <= above_q;
			mid_s1   <= middle_q;
			dn_s1    <= cur;
			imask_s1 <= imask;
			rnum_s1  <= row_cnt_q;
		end
	end

	cave_row_unit #(
		.WIDTH (MAX_WIDTH)
	) u_row (
		.up    (up_s1),
		.mid   (mid_s1),
		.dn    (dn_s1),
		.imask (imask_s1),
		.birth (birth_q),
		.death (death_q),
		.nrow  (nrow)
	);

	// result beat selection
	always_comb begin
		res              = '0;
		res.last_of_run  = last_emit;
		case (kind_s1)
			KIND_ZERO: begin
				res.row_number = rnum_s1;
			end
			KIND_NORMAL: begin
				res.new_row[MAX_WIDTH-1:0] = nrow;
				res.row_number             = rnum_s1 - 16'd1;
			end
			KIND_FINAL: begin
				if (phase_s1) begin
					res.row_number   = rnum_s1;
					res.last_of_grid = 1'b1;
				end else begin
					res.new_row[MAX_WIDTH-1:0] = nrow;
					res.row_number             = rnum_s1 - 16'd1;
				end
			end
			default: ;
		endcase
	end

	cave_out_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_data  (res),
		.push_ready (q_ready),
		.pop_valid  (out_valid),
		.pop_ready  (out_ready),
		.pop_data   (q_data)
	);

	assign new_row      = q_data.new_row;
	assign row_number   = q_data.row_number;
	assign last_of_grid = q_data.last_of_grid;
	assign last_of_run  = q_data.last_of_run;

endmodule

// ===== rtl/cave_chk.sv =====
module cave_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_ready,
	input logic [63:0] new_row,
	input logic [15:0] row_number,
	input logic        last_of_grid,
	input logic        last_of_run
);

	// a stalled result beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(new_row) && $stable(row_number))
		else $error("result beat changed while stalled");

	// the closing row of a grid is empty and ends the run
	a_final_row: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && last_of_grid |-> last_of_run && new_row == 64'd0)
		else $error("closing row not empty or not last of run");

	// a grid has at least three rows
	a_final_num: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && last_of_grid |-> row_number >= 16'd2)
		else $error("closing row number too small");

	// the top row is empty and stands alone
	a_top_row: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && row_number == 16'd0 |-> new_row == 64'd0 && last_of_run)
		else $error("top row not empty");

endmodule

bind cave_automaton_row_step_core cave_chk u_cave_chk (
	.clk          (clk),
	.arst_n       (arst_n),
	.out_valid    (out_valid),
	.out_ready    (out_ready),
	.new_row      (new_row),
	.row_number   (row_number),
	.last_of_grid (last_of_grid),
	.last_of_run  (last_of_run)
);
